// File: rtl/cpqs_pkg.sv
// Shared types and constants of the coupled priority queue scheduler.
// Used by the channel interfaces, the controller and the top level.
// Depends on nothing.
package cpqs_pkg;

  // Fixed field widths of the channels.
  localparam int QIDX_W     = 3;
  localparam int QIU_W      = 4;
  localparam int LLQ_W      = 3;
  localparam int CAP_W      = 16;
  localparam int RUN_W      = 16;
  localparam int FTOT_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes of an input beat.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SELECT  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUEUES_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LATENCY_QUEUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_CAP         = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [QIU_W-1:0] QIU_RESET = 4'd8;
  localparam logic [LLQ_W-1:0] LLQ_RESET = 3'd0;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd8;

  typedef struct packed {
    logic [QIU_W-1:0] queues_in_use;
    logic [LLQ_W-1:0] low_latency_queue;
    logic [CAP_W-1:0] burst_cap;
  } cpqs_cfg_t;

  typedef struct packed {
    logic              operation;
    logic [QIDX_W-1:0] queue_index;
  } cpqs_item_t;

  typedef struct packed {
    logic              granted;
    logic [QIDX_W-1:0] served_queue;
    logic              forced_classic;
    logic [FTOT_W-1:0] forced_total;
    logic [RUN_W-1:0]  burst_run;
  } cpqs_result_t;

endpackage

// File: rtl/cpqs_if.sv
// Valid/ready channel interfaces of the scheduler: input, result and config.
// Depends on cpqs_pkg for the field widths.
interface cpqs_in_if import cpqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [QIDX_W-1:0] queue_index;

  modport source (output valid, output operation, output queue_index, input ready);
  modport sink   (input valid, input operation, input queue_index, output ready);
endinterface

interface cpqs_out_if import cpqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [QIDX_W-1:0] served_queue;
  logic              forced_classic;
  logic [FTOT_W-1:0] forced_total;
  logic [RUN_W-1:0]  burst_run;

  modport source (output valid, output granted, output served_queue, output forced_classic,
                  output forced_total, output burst_run, input ready);
  modport sink   (input valid, input granted, input served_queue, input forced_classic,
                  input forced_total, input burst_run, output ready);
endinterface

interface cpqs_cfg_if import cpqs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/coupled_priority_queue_scheduler.sv
// Coupled low-latency / classic priority queue scheduler with a burst cap.
// Top level: configuration registers, result register, controller and count store.
// Depends on cpqs_pkg, the channel interfaces, cpqs_ctrl and cpqs_count_ram.
//
// Usage: in_i takes one beat per item: an enqueue adds a packet to a queue, a
// selection picks the next queue and removes one packet from it. Every beat
// gives exactly one result beat on out_o. cfg_i writes a register by index
// (0 queue count, 1 low-latency queue, 2 burst cap); it is always ready and is
// meant to be written while no item is in flight.
// Sequence: an enqueue reads the queue's count and writes it back plus one,
// saturating. A selection first brings a cursor that lies beyond a reduced
// queue count back into range, reads the low-latency count and then scans
// the classic queues one count-store read per cycle. in_i is ready only
// while the controller is idle. A result enters the output register as the
// controller leaves its done state.
// Reset clears all counts, the run counter, the cursor, the forced total and
// the registers to 8 queues, queue 0, burst cap 8. When the receiver stalls,
// the result waits in the output register; the block still takes the next
// item and holds its result until the register frees up.
module coupled_priority_queue_scheduler import cpqs_pkg::*; #(
  parameter int MAX_QUEUES  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpqs_in_if.sink    in_i,
  cpqs_cfg_if.sink   cfg_i,
  cpqs_out_if.source out_o
);

  localparam int QW = $clog2(MAX_QUEUES);

  cpqs_cfg_t    cfg_q;
  cpqs_item_t   item;
  cpqs_result_t res;
  cpqs_result_t out_q;
  logic         out_valid_q;
  logic         res_valid;
  logic         res_ready;
  logic         in_ready;

  logic [QW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [QW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.queues_in_use     <= QIU_RESET;
      cfg_q.low_latency_queue <= LLQ_RESET;
      cfg_q.burst_cap         <= CAP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_QUEUES_IN_USE:     cfg_q.queues_in_use     <= cfg_i.data[QIU_W-1:0];
        REG_LOW_LATENCY_QUEUE: cfg_q.low_latency_queue <= cfg_i.data[LLQ_W-1:0];
        REG_BURST_CAP:         cfg_q.burst_cap         <= cfg_i.data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.operation   = in_i.operation;
  assign item.queue_index = in_i.queue_index;
  assign in_i.ready       = in_ready;

  cpqs_ctrl #(
    .MAX_QUEUES  (MAX_QUEUES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_item_i   (item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  cpqs_count_ram #(
    .DEPTH (MAX_QUEUES),
    .WIDTH (COUNT_WIDTH)
  ) u_count_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.granted        = out_q.granted;
  assign out_o.served_queue   = out_q.served_queue;
  assign out_o.forced_classic = out_q.forced_classic;
  assign out_o.forced_total   = out_q.forced_total;
  assign out_o.burst_run      = out_q.burst_run;

  // The controller is busy right after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted again while an item is in progress");

  // A forced grant is a grant and always clears the run.
  a_forced_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.forced_classic |-> out_q.granted && (out_q.burst_run == '0))
    else $error("forced beat without a grant or with a nonzero run");

  // A result handed over by the controller lands in the output register.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_q)
    else $error("result lost between controller and output register");

endmodule

// File: rtl/cpqs_count_ram.sv
// Per-queue packet count store: one write port, one registered read port.
// Entries read as zero until first written after reset. No package use.
module cpqs_count_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/cpqs_ctrl.sv
// Sequencer of the scheduler: enqueue update, round-robin classic scan and
// grant decision, one count read per cycle. Depends on cpqs_pkg.
module cpqs_ctrl import cpqs_pkg::*; #(
  parameter int MAX_QUEUES  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cpqs_item_t                    in_item_i,
  input  cpqs_cfg_t                     cfg_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output cpqs_result_t                  res_o,
  output logic [$clog2(MAX_QUEUES)-1:0] rd_addr_o,
  input  logic [COUNT_WIDTH-1:0]        rd_data_i,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_QUEUES)-1:0] wr_addr_o,
  output logic [COUNT_WIDTH-1:0]        wr_data_o
);

  localparam int QW = $clog2(MAX_QUEUES);
  localparam int NW = $clog2(MAX_QUEUES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ_RD, S_ENQ_WR, S_REDUCE, S_LL_RD, S_LL_CHK, S_SCAN, S_DECIDE, S_DONE
  } state_e;

  state_e             state_q;
  logic [QW-1:0]      qi_q;
  logic [QW-1:0]      idx_q;
  logic [NW-1:0]      k_q;
  logic               chk_v_q;
  logic [QW-1:0]      chk_idx_q;
  logic               hit_q;
  logic [QW-1:0]      hit_idx_q;
  logic [COUNT_WIDTH-1:0] hit_cnt_q;
  logic               ll_nz_q;
  logic [COUNT_WIDTH-1:0] ll_cnt_q;
  logic [RUN_W-1:0]   run_q;
  logic [QW-1:0]      cursor_q;
  logic [FTOT_W-1:0]  forced_q;
  cpqs_result_t       res_q;

  logic [NW-1:0] n_eff;
  logic          ll_valid;
  logic [QW-1:0] ll_addr;
  logic          enq_ok;
  logic [NW-1:0] idx_inc;
  logic [QW-1:0] idx_next;
  logic [NW-1:0] hit_inc;
  logic [QW-1:0] hit_next;
  logic          chk_hit;
  logic          force_cls;
  logic          serve_ll;
  logic          grant_cls;
  logic [RUN_W-1:0] run_inc;

  // Effective queue count: zero acts as one, anything above the store depth is clamped.
  always_comb begin
    if (cfg_i.queues_in_use == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_i.queues_in_use) > MAX_QUEUES) begin
      n_eff = NW'(MAX_QUEUES);
    end else begin
      n_eff = NW'(cfg_i.queues_in_use);
    end
  end

  assign ll_valid = int'(cfg_i.low_latency_queue) < int'(n_eff);
  assign ll_addr  = ll_valid ? QW'(cfg_i.low_latency_queue) : '0;
  assign enq_ok   = int'(in_item_i.queue_index) < int'(n_eff);

  // Modulo-n successors of the scan pointer and of the hit index; the latter feeds the cursor update.
  assign idx_inc  = NW'(idx_q) + NW'(1);
  assign idx_next = (idx_inc == n_eff) ? '0 : QW'(idx_inc);
  assign hit_inc  = NW'(hit_idx_q) + NW'(1);
  assign hit_next = (hit_inc == n_eff) ? '0 : QW'(hit_inc);

  // The low-latency index is skipped by its raw register value, whether or not it lies in the active range.
  assign chk_hit = chk_v_q && (int'(chk_idx_q) != int'(cfg_i.low_latency_queue))
                   && (rd_data_i != '0);

  assign force_cls = (run_q >= cfg_i.burst_cap) && hit_q;
  assign serve_ll  = !force_cls && ll_nz_q;
  assign grant_cls = !force_cls && !ll_nz_q && hit_q;
  assign run_inc   = (run_q == '1) ? run_q : run_q + RUN_W'(1);

  always_comb begin
    unique case (state_q)
      S_ENQ_RD: rd_addr_o = qi_q;
      S_LL_RD:  rd_addr_o = ll_addr;
      S_SCAN:   rd_addr_o = idx_q;
      default:  rd_addr_o = '0;
    endcase
  end

  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = hit_idx_q;
    wr_data_o = hit_cnt_q - COUNT_WIDTH'(1);
    if (state_q == S_ENQ_WR) begin
      wr_en_o   = rd_data_i != '1;
      wr_addr_o = qi_q;
      wr_data_o = rd_data_i + COUNT_WIDTH'(1);
    end else if (state_q == S_DECIDE) begin
      wr_en_o = force_cls || serve_ll || grant_cls;
      if (serve_ll) begin
        wr_addr_o = ll_addr;
        wr_data_o = ll_cnt_q - COUNT_WIDTH'(1);
      end
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      qi_q      <= '0;
      idx_q     <= '0;
      k_q       <= '0;
      chk_v_q   <= 1'b0;
      chk_idx_q <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      hit_cnt_q <= '0;
      ll_nz_q   <= 1'b0;
      ll_cnt_q  <= '0;
      run_q     <= '0;
      cursor_q  <= '0;
      forced_q  <= '0;
      res_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_item_i.operation == OP_ENQUEUE) begin
              if (enq_ok) begin
                qi_q    <= QW'(in_item_i.queue_index);
                state_q <= S_ENQ_RD;
              end else begin
                res_q   <= '{granted: 1'b0, served_queue: '0, forced_classic: 1'b0,
                             forced_total: forced_q, burst_run: run_q};
                state_q <= S_DONE;
              end
            end else begin
              idx_q   <= cursor_q;
              state_q <= S_REDUCE;
            end
          end
        end
        S_ENQ_RD: begin
          state_q <= S_ENQ_WR;
        end
        S_ENQ_WR: begin
          res_q   <= '{granted: 1'b0, served_queue: '0, forced_classic: 1'b0,
                       forced_total: forced_q, burst_run: run_q};
          state_q <= S_DONE;
        end
        S_REDUCE: begin
          // A cursor left beyond a reduced queue count is brought into range here.
          if (NW'(idx_q) >= n_eff) begin
            idx_q <= QW'(NW'(idx_q) - n_eff);
          end else begin
            state_q <= S_LL_RD;
          end
        end
        S_LL_RD: begin
          state_q <= S_LL_CHK;
        end
        S_LL_CHK: begin
          ll_nz_q  <= ll_valid && (rd_data_i != '0);
          ll_cnt_q <= rd_data_i;
          k_q      <= '0;
          chk_v_q  <= 1'b0;
          hit_q    <= 1'b0;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          // One read is issued per cycle and checked in the next.
          if (int'(k_q) < int'(n_eff)) begin
            chk_v_q   <= 1'b1;
            chk_idx_q <= idx_q;
            idx_q     <= idx_next;
            k_q       <= k_q + NW'(1);
          end else begin
            chk_v_q <= 1'b0;
          end
          if (chk_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= chk_idx_q;
            hit_cnt_q <= rd_data_i;
            state_q   <= S_DECIDE;
          end else if (k_q == n_eff) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (force_cls) begin
            run_q    <= '0;
            forced_q <= forced_q + FTOT_W'(1);
            cursor_q <= hit_next;
            res_q    <= '{granted: 1'b1, served_queue: QIDX_W'(hit_idx_q),
                          forced_classic: 1'b1, forced_total: forced_q + FTOT_W'(1),
                          burst_run: '0};
          end else if (serve_ll) begin
            run_q <= run_inc;
            res_q <= '{granted: 1'b1, served_queue: cfg_i.low_latency_queue,
                       forced_classic: 1'b0, forced_total: forced_q, burst_run: run_inc};
          end else if (grant_cls) begin
            run_q    <= '0;
            cursor_q <= hit_next;
            res_q    <= '{granted: 1'b1, served_queue: QIDX_W'(hit_idx_q),
                          forced_classic: 1'b0, forced_total: forced_q, burst_run: '0};
          end else begin
            run_q <= '0;
            res_q <= '{granted: 1'b0, served_queue: '0, forced_classic: 1'b0,
                       forced_total: forced_q, burst_run: '0};
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
